// ----- src/gha_pkg.sv -----
package gha_pkg;

  localparam int MAX_IDS = 1024;
  localparam int ID_W    = $clog2(MAX_IDS);
  localparam int CNT_W   = ID_W + 1;
  localparam int GEN_W   = 16;
  localparam int WORD_W  = GEN_W + 1;

  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_RECLAIM = 2'd1,
    OP_QUERY   = 2'd2,
    OP_CLEAR   = 2'd3
  } gha_op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_NOTALIVE = 3'd3,
    ST_RANGE    = 3'd4
  } gha_status_e;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_READ, S_EVAL, S_SCAN, S_CLEAR, S_RESP
  } gha_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init;
    logic ld_req;
    logic rd_req;
    logic eval;
    logic scan_start;
    logic scan;
    logic take;
    logic scan_full;
    logic clr_start;
    logic clr;
    logic load_out;
  } gha_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    gha_op_e op;
    logic    init_done;
    logic    go_scan;
    logic    scan_found;
    logic    scan_fail;
    logic    sweep_done;
    logic    out_free;
  } gha_stat_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [ID_W-1:0]  handle_id;
    logic [GEN_W-1:0] handle_generation;
    logic             id_alive;
    logic             handle_alive;
    logic [CNT_W-1:0] live_count;
  } gha_res_t;

endpackage

// ----- src/gha_if.sv -----
interface gha_req_if;
  import gha_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       op;
  logic [ID_W-1:0]  entity_id;
  logic [GEN_W-1:0] generation;

  modport source (output valid, op, entity_id, generation, input ready);
  modport sink   (input valid, op, entity_id, generation, output ready);
endinterface

interface gha_rsp_if;
  import gha_pkg::*;
  logic             valid;
  logic             ready;
  logic [2:0]       status;
  logic [ID_W-1:0]  handle_id;
  logic [GEN_W-1:0] handle_generation;
  logic             id_alive;
  logic             handle_alive;
  logic [CNT_W-1:0] live_count;

  modport source (output valid, status, handle_id, handle_generation, id_alive,
                  handle_alive, live_count, input ready);
  modport sink   (input valid, status, handle_id, handle_generation, id_alive,
                  handle_alive, live_count, output ready);
endinterface

// ----- src/gha_datapath.sv -----
module gha_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  gha_pkg::gha_cmd_t               cmd_i,
  output gha_pkg::gha_stat_t              stat_o,
  input  logic                            cfg_we_i,
  input  logic [gha_pkg::CNT_W-1:0]       cfg_wdata_i,
  input  logic [1:0]                      req_op_i,
  input  logic [gha_pkg::ID_W-1:0]        req_id_i,
  input  logic [gha_pkg::GEN_W-1:0]       req_gen_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output gha_pkg::gha_res_t               out_res_o
);
  import gha_pkg::*;

  // Each word holds the live bit above the generation.
  logic [WORD_W-1:0] mem [MAX_IDS];

  logic [CNT_W-1:0] cap_q, count_q, count_d;
  logic [ID_W-1:0]  next_q, next_d;
  gha_op_e          op_q;
  logic [ID_W-1:0]  eid_q;
  logic [GEN_W-1:0] gen_q;
  logic [ID_W-1:0]  rd_addr_q, scan_q, init_q;
  logic             rd_vld_q;
  logic [CNT_W-1:0] sweep_q;
  logic [WORD_W-1:0] rd_data_q;
  gha_res_t         res_q, res_d, out_res_q;
  logic             out_valid_q;

  logic [CNT_W-1:0] eff_cap;
  logic             rd_live, addr_ok, count_full, ptr_free, sweep_issue;
  logic [GEN_W-1:0] rd_gen, gen_next;
  logic [CNT_W-1:0] addr_inc;
  logic [ID_W-1:0]  rd_sel;
  logic             rd_en, we;
  logic [ID_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_data;

  // Effective capacity and read word decode.
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CNT_W'(1);
    end else if (cap_q > CNT_W'(MAX_IDS)) begin
      eff_cap = CNT_W'(MAX_IDS);
    end else begin
      eff_cap = cap_q;
    end
  end

  assign rd_live     = rd_data_q[GEN_W];
  assign rd_gen      = rd_data_q[GEN_W-1:0];
  assign gen_next    = rd_gen + GEN_W'(2);
  assign addr_inc    = {1'b0, rd_addr_q} + CNT_W'(1);
  assign addr_ok     = {1'b0, rd_addr_q} < eff_cap;
  assign count_full  = count_q >= eff_cap;
  assign ptr_free    = addr_ok && !rd_live;
  assign sweep_issue = sweep_q < CNT_W'(MAX_IDS);

  // Status toward the controller.
  always_comb begin
    stat_o.op         = op_q;
    stat_o.init_done  = init_q == ID_W'(MAX_IDS - 1);
    stat_o.go_scan    = (op_q == OP_CREATE) && !count_full && !ptr_free;
    stat_o.scan_found = rd_vld_q && ptr_free;
    stat_o.scan_fail  = rd_vld_q && !ptr_free && (addr_inc >= eff_cap);
    stat_o.sweep_done = rd_vld_q && (rd_addr_q == ID_W'(MAX_IDS - 1));
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  // Read address selection.
  always_comb begin
    rd_en  = 1'b0;
    rd_sel = scan_q;
    if (cmd_i.rd_req) begin
      rd_en  = 1'b1;
      rd_sel = (op_q == OP_CREATE) ? next_q : eid_q;
    end else if (cmd_i.scan) begin
      rd_en  = 1'b1;
      rd_sel = scan_q;
    end else if (cmd_i.clr) begin
      rd_en  = sweep_issue;
      rd_sel = sweep_q[ID_W-1:0];
    end
  end

  // Commit of each operation: table write, counters and the result.
  always_comb begin
    we      = 1'b0;
    wr_addr = rd_addr_q;
    wr_data = {1'b0, gen_next};
    count_d = count_q;
    next_d  = next_q;
    res_d   = res_q;
    if (cmd_i.init) begin
      we      = 1'b1;
      wr_addr = init_q;
      wr_data = {1'b0, GEN_W'(1)};
    end else if (cmd_i.clr) begin
      we = rd_vld_q;
    end else if (cmd_i.clr_start) begin
      count_d = '0;
      next_d  = '0;
      res_d   = '{ST_OK, eid_q, '0, 1'b0, 1'b0, '0};
    end else if (cmd_i.take ||
                 (cmd_i.eval && op_q == OP_CREATE && !count_full && ptr_free)) begin
      we      = 1'b1;
      wr_data = {1'b1, rd_gen};
      count_d = count_q + CNT_W'(1);
      next_d  = (addr_inc >= eff_cap) ? '0 : addr_inc[ID_W-1:0];
      res_d   = '{ST_OK, rd_addr_q, rd_gen, 1'b1, 1'b1, count_q + CNT_W'(1)};
    end else if (cmd_i.scan_full || (cmd_i.eval && op_q == OP_CREATE && count_full)) begin
      res_d = '{ST_FULL, eid_q, '0, 1'b0, 1'b0, count_q};
    end else if (cmd_i.eval && (op_q == OP_RECLAIM || op_q == OP_QUERY)) begin
      if (!addr_ok) begin
        res_d = '{ST_RANGE, eid_q, '0, 1'b0, 1'b0, count_q};
      end else if (op_q == OP_QUERY) begin
        res_d = '{ST_OK, eid_q, rd_gen, rd_live, rd_live && (rd_gen == gen_q), count_q};
      end else if (rd_gen != gen_q) begin
        res_d = '{ST_MISMATCH, eid_q, rd_gen, rd_live, 1'b0, count_q};
      end else if (!rd_live) begin
        res_d = '{ST_NOTALIVE, eid_q, rd_gen, 1'b0, 1'b0, count_q};
      end else begin
        we      = 1'b1;
        count_d = (count_q != '0) ? count_q - CNT_W'(1) : count_q;
        res_d   = '{ST_OK, eid_q, gen_next, 1'b0, 1'b0,
                    (count_q != '0) ? count_q - CNT_W'(1) : count_q};
      end
    end
  end

  // Generation table with live bits.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_sel];
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CNT_W'(MAX_IDS);
      count_q     <= '0;
      next_q      <= '0;
      rd_vld_q    <= 1'b0;
      rd_addr_q   <= '0;
      scan_q      <= '0;
      sweep_q     <= '0;
      init_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      count_q <= count_d;
      next_q  <= next_d;
      if (cmd_i.init) begin
        init_q <= init_q + ID_W'(1);
      end
      if (cmd_i.rd_req) begin
        rd_addr_q <= rd_sel;
      end else if (cmd_i.scan_start || cmd_i.clr_start) begin
        rd_vld_q <= 1'b0;
        scan_q   <= '0;
        sweep_q  <= '0;
      end else if (cmd_i.scan) begin
        rd_vld_q  <= 1'b1;
        rd_addr_q <= scan_q;
        scan_q    <= scan_q + ID_W'(1);
      end else if (cmd_i.clr) begin
        rd_vld_q <= sweep_issue;
        if (sweep_issue) begin
          rd_addr_q <= sweep_q[ID_W-1:0];
          sweep_q   <= sweep_q + CNT_W'(1);
        end
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request and result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_req) begin
      op_q  <= gha_op_e'(req_op_i);
      eid_q <= req_id_i;
      gen_q <= req_gen_i;
    end
    res_q <= res_d;
    if (cmd_i.load_out) begin
      out_res_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

// ----- src/gha_ctrl.sv -----
module gha_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  gha_pkg::gha_stat_t  stat_i,
  output gha_pkg::gha_cmd_t   cmd_o
);
  import gha_pkg::*;

  gha_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_INIT: begin
        cmd_o.init = 1'b1;
        if (stat_i.init_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.ld_req = 1'b1;
          state_d      = S_READ;
        end
      end
      S_READ: begin
        if (stat_i.op == OP_CLEAR) begin
          cmd_o.clr_start = 1'b1;
          state_d         = S_CLEAR;
        end else begin
          cmd_o.rd_req = 1'b1;
          state_d      = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat_i.go_scan) begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SCAN;
        end else begin
          cmd_o.eval = 1'b1;
          state_d    = S_RESP;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_found) begin
          cmd_o.take = 1'b1;
          state_d    = S_RESP;
        end else if (stat_i.scan_fail) begin
          cmd_o.scan_full = 1'b1;
          state_d         = S_RESP;
        end
      end
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (stat_i.sweep_done) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ----- src/generational_handle_allocator.sv -----
// Generational handle allocator.
// Requests arrive on req_i (op, entity_id, generation) with valid/ready and
// one response per request leaves on rsp_o (status, handle_id,
// handle_generation, id_alive, handle_alive, live_count).
// The capacity register is written through cfg_we_i/cfg_wdata_i; the user
// must write it only while idle, as the block itself does not enforce this.
// Reclaim, query, and a create that finds the next-fit ID free or the count at
// capacity go from acceptance through the read, evaluate and response states;
// the next request is accepted back in idle. Otherwise create scans the
// table from ID 0 one entry per cycle through the single read port,
// stopping at the lowest free ID, or reporting full when no ID below the
// capacity is free. Clear sweeps all 1024 entries with read-modify-write.
// One request is worked on at a time; a new request is accepted while the
// previous response still waits in the output register, and its result holds
// until that register is free, so a stalled receiver stalls the block.
// After reset the table is swept to generation 1 and not live, and no
// request is accepted during the sweep; the capacity register accepts writes
// during the sweep and resets to 1024.
module generational_handle_allocator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [gha_pkg::CNT_W-1:0]  cfg_wdata_i,
  gha_req_if.sink                    req_i,
  gha_rsp_if.source                  rsp_o
);
  import gha_pkg::*;

  gha_cmd_t  cmd;
  gha_stat_t stat;
  gha_res_t  res;
  logic      out_valid;

  gha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  gha_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_op_i    (req_i.op),
    .req_id_i    (req_i.entity_id),
    .req_gen_i   (req_i.generation),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (out_valid),
    .out_res_o   (res)
  );

  // Response channel.
  assign rsp_o.valid             = out_valid;
  assign rsp_o.status            = res.status;
  assign rsp_o.handle_id         = res.handle_id;
  assign rsp_o.handle_generation = res.handle_generation;
  assign rsp_o.id_alive          = res.id_alive;
  assign rsp_o.handle_alive      = res.handle_alive;
  assign rsp_o.live_count        = res.live_count;

endmodule

// ----- sim/tb_gha_if.sv -----
`timescale 1ns / 100ps
// The block's own request and response interfaces are reused; this file holds
// a small interface that carries the request for the receiver's long hold-off.
interface tb_hold_if;
  logic hold;
endinterface

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
module tb_top;
  import gha_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CNT_W-1:0] cfg_wdata_i = '0;

  gha_req_if req_if ();
  gha_rsp_if rsp_if ();
  tb_hold_if stall_if ();

  generational_handle_allocator dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .req_i(req_if.sink), .rsp_o(rsp_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Allocator state as the bench sees it.
  logic             alloc_live [MAX_IDS];
  logic [GEN_W-1:0] alloc_gen [MAX_IDS];
  int unsigned      alloc_next;
  int unsigned      alloc_count;
  int unsigned      alloc_cap;

  gha_res_t expected_q [$];
  int errors = 0;
  int idle_cycles = 0;
  int stall_cycles = 0;

  function automatic int unsigned clamp_cap(int unsigned c);
    if (c < 1) return 1;
    if (c > MAX_IDS) return MAX_IDS;
    return c;
  endfunction

  // Work out the response for one request and advance the state.
  function automatic gha_res_t alloc_step(gha_op_e op, int unsigned eid,
                                          logic [GEN_W-1:0] g);
    gha_res_t r;
    int unsigned cap;
    int unsigned id;
    bit found;
    cap = clamp_cap(alloc_cap);
    found = 0;
    r = '0;
    r.status = ST_OK;
    r.handle_id = eid[ID_W-1:0];
    case (op)
      OP_CREATE: begin
        id = alloc_next;
        if (alloc_count < cap) begin
          if (id < cap && !alloc_live[id]) begin
            found = 1;
          end else begin
            for (int i = 0; i < cap; i++) begin
              if (!alloc_live[i]) begin
                id = i;
                found = 1;
                break;
              end
            end
          end
        end
        if (!found) begin
          r.status = ST_FULL;
        end else begin
          alloc_live[id] = 1'b1;
          alloc_next = (id + 1 >= cap) ? 0 : id + 1;
          alloc_count++;
          r.handle_id = id[ID_W-1:0];
          r.handle_generation = alloc_gen[id];
          r.id_alive = 1'b1;
          r.handle_alive = 1'b1;
        end
      end
      OP_RECLAIM: begin
        if (eid >= cap) begin
          r.status = ST_RANGE;
        end else begin
          if (alloc_gen[eid] != g) begin
            r.status = ST_MISMATCH;
          end else if (!alloc_live[eid]) begin
            r.status = ST_NOTALIVE;
          end else begin
            alloc_gen[eid] = alloc_gen[eid] + 16'd2;
            alloc_live[eid] = 1'b0;
            if (alloc_count > 0) alloc_count--;
          end
          r.handle_generation = alloc_gen[eid];
          r.id_alive = alloc_live[eid];
          r.handle_alive = alloc_live[eid] && alloc_gen[eid] == g;
        end
      end
      OP_QUERY: begin
        if (eid >= cap) begin
          r.status = ST_RANGE;
        end else begin
          r.handle_generation = alloc_gen[eid];
          r.id_alive = alloc_live[eid];
          r.handle_alive = alloc_live[eid] && alloc_gen[eid] == g;
        end
      end
      default: begin
        for (int i = 0; i < MAX_IDS; i++) begin
          alloc_live[i] = 1'b0;
          alloc_gen[i] = alloc_gen[i] + 16'd2;
        end
        alloc_count = 0;
        alloc_next = 0;
      end
    endcase
    r.live_count = alloc_count[CNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // Send one request; returns after it is accepted.
  task automatic send_request(gha_op_e op, int unsigned eid, logic [GEN_W-1:0] g);
    req_if.valid <= 1'b1;
    req_if.op <= op;
    req_if.entity_id <= eid[ID_W-1:0];
    req_if.generation <= g;
    do @(posedge clk_i); while (!req_if.ready);
    expected_q.push_back(alloc_step(op, eid, g));
  endtask

  task automatic drop_valid();
    req_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    drop_valid();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cap(int unsigned c);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= c[CNT_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    alloc_cap = c;
  endtask

  // Pick an ID that is usually below the capacity.
  function automatic int unsigned pick_id();
    int unsigned cap;
    cap = clamp_cap(alloc_cap);
    if ($urandom_range(9) == 0) return $urandom_range(MAX_IDS - 1);
    return $urandom_range(cap - 1);
  endfunction

  function automatic logic [GEN_W-1:0] pick_gen(int unsigned id);
    case ($urandom_range(5))
      0: return GEN_W'($urandom);
      1: return alloc_gen[id] - 16'd2;
      default: return alloc_gen[id];
    endcase
  endfunction

  // Receiver: stalls on its own pattern, with one long hold-off counted here.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else if (stall_if.hold && stall_cycles < 300) begin
      rsp_if.ready <= 1'b0;
      stall_cycles <= stall_cycles + 1;
    end else begin
      rsp_if.ready <= ($urandom_range(3) != 0) || ($time / 5000) % 3 == 0;
    end
  end

  // Response checker.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected response", 1, 0);
      end else begin
        gha_res_t e;
        e = expected_q.pop_front();
        if (rsp_if.status != e.status)
          report_mismatch("status", rsp_if.status, e.status);
        if (rsp_if.handle_id != e.handle_id)
          report_mismatch("handle_id", rsp_if.handle_id, e.handle_id);
        if (rsp_if.handle_generation != e.handle_generation)
          report_mismatch("handle_generation", rsp_if.handle_generation,
                          e.handle_generation);
        if (rsp_if.id_alive != e.id_alive)
          report_mismatch("id_alive", rsp_if.id_alive, e.id_alive);
        if (rsp_if.handle_alive != e.handle_alive)
          report_mismatch("handle_alive", rsp_if.handle_alive, e.handle_alive);
        if (rsp_if.live_count != e.live_count)
          report_mismatch("live_count", rsp_if.live_count, e.live_count);
      end
    end
  end

  // Watchdog on cycles with no request or response accepted.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Directed rows: expected values given where they are plain, else predicted.
  typedef struct {
    gha_op_e          op;
    int unsigned      eid;
    logic [GEN_W-1:0] g;
    bit               fixed;
    logic [2:0]       st;
    logic [CNT_W-1:0] cnt;
  } row_t;

  row_t rows [] = '{
    '{OP_QUERY,   0,    16'd1,     1, ST_OK,       0},
    '{OP_RECLAIM, 0,    16'd1,     1, ST_NOTALIVE, 0},
    '{OP_RECLAIM, 5,    16'd0,     1, ST_MISMATCH, 0},
    '{OP_CREATE,  0,    16'd0,     1, ST_OK,       1},
    '{OP_CREATE,  0,    16'd0,     1, ST_OK,       2},
    '{OP_QUERY,   1,    16'd1,     0, ST_OK,       0},
    '{OP_QUERY,   1,    16'd3,     0, ST_OK,       0},
    '{OP_RECLAIM, 1,    16'd1,     1, ST_OK,       1},
    '{OP_RECLAIM, 1,    16'd1,     1, ST_MISMATCH, 1},
    '{OP_RECLAIM, 1023, 16'hffff,  1, ST_MISMATCH, 1},
    '{OP_QUERY,   1023, 16'hffff,  0, ST_OK,       0},
    '{OP_CREATE,  1023, 16'hffff,  0, ST_OK,       0},
    '{OP_CLEAR,   0,    16'd0,     1, ST_OK,       0},
    '{OP_QUERY,   0,    16'd3,     0, ST_OK,       0},
    '{OP_CREATE,  0,    16'd0,     0, ST_OK,       0}
  };

  initial begin
    int unsigned id;
    int burst;
    gha_op_e op;
    stall_if.hold = 1'b0;
    req_if.valid = 1'b0;
    req_if.op = OP_CREATE;
    req_if.entity_id = '0;
    req_if.generation = '0;
    for (int i = 0; i < MAX_IDS; i++) begin
      alloc_live[i] = 1'b0;
      alloc_gen[i] = 16'd1;
    end
    alloc_next = 0;
    alloc_count = 0;
    alloc_cap = 1024;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[k]) begin
      send_request(rows[k].op, rows[k].eid, rows[k].g);
      if (rows[k].fixed) begin
        expected_q[$].status = rows[k].st;
        expected_q[$].live_count = rows[k].cnt;
      end
    end
    wait_drained();

    // Small and out-of-range capacities: full, ID beyond capacity, pointer beyond capacity.
    write_cap(0);
    send_request(OP_CREATE, 0, 0);
    send_request(OP_CREATE, 0, 0);
    send_request(OP_QUERY, 1, 1);
    send_request(OP_RECLAIM, 1023, 1);
    wait_drained();
    write_cap(2047);
    send_request(OP_CREATE, 0, 0);
    send_request(OP_CREATE, 0, 0);
    wait_drained();
    write_cap(3);
    send_request(OP_CREATE, 0, 0);
    send_request(OP_CREATE, 0, 0);
    wait_drained();

    // Random phases at several capacities, mostly small.
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: write_cap(1);
        1: write_cap(1024);
        2: write_cap(1025);
        default: write_cap($urandom_range(2, 40));
      endcase
      for (int n = 0; n < 150; ) begin
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst && n < 150; b++, n++) begin
          case ($urandom_range(19))
            0, 1, 2, 3, 4, 5, 6: op = OP_CREATE;
            7, 8, 9, 10, 11, 12: op = OP_RECLAIM;
            19: op = (ph % 3 == 0) ? OP_CLEAR : OP_QUERY;
            default: op = OP_QUERY;
          endcase
          id = pick_id();
          if (ph == 4 && n == 20) stall_if.hold = 1'b1;
          send_request(op, id, pick_gen(id));
        end
        if (ph == 6 && n > 80 && n < 95) begin
          wait_drained();
        end else if ($urandom_range(2) == 0) begin
          drop_valid();
          repeat ($urandom_range(1, 15)) @(posedge clk_i);
        end
      end
      wait_drained();
    end

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
src/gha_pkg.sv
src/gha_if.sv
src/gha_datapath.sv
src/gha_ctrl.sv
src/generational_handle_allocator.sv
sim/tb_gha_if.sv
sim/tb_top.sv
